>>> rtl/core/iwce_pkg.sv
// Shared types, constants and lattice helpers for the Wolff cluster engine.
// No dependencies.
package iwce_pkg;

    localparam int SIDE      = 64;
    localparam int NSITES    = SIDE * SIDE;
    localparam int SITE_W    = 12;
    localparam int ROW_W     = $clog2(SIDE);
    localparam int COUNT_W   = 13;
    localparam int SUM_W     = 14;
    localparam int WORD_W    = 16;
    // Spin sum of the checkerboard: one extra up site when the site count is odd
    localparam int CB_SUM    = NSITES % 2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_DRAW  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    function automatic logic [SITE_W-1:0] neighbor_of(input logic [SITE_W-1:0] s,
                                                      input logic [1:0] dir);
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic [ROW_W-1:0] nrow;
        logic [ROW_W-1:0] ncol;
        row  = ROW_W'(s / SIDE);
        col  = ROW_W'(s % SIDE);
        nrow = row;
        ncol = col;
        case (dir)
            DIR_UP:    nrow = (row == '0) ? ROW_W'(SIDE - 1) : row - 1'b1;
            DIR_DOWN:  nrow = (row == ROW_W'(SIDE - 1)) ? '0 : row + 1'b1;
            DIR_LEFT:  ncol = (col == '0) ? ROW_W'(SIDE - 1) : col - 1'b1;
            DIR_RIGHT: ncol = (col == ROW_W'(SIDE - 1)) ? '0 : col + 1'b1;
            default:   nrow = row;
        endcase
        return SITE_W'(nrow * SIDE) + SITE_W'(ncol);
    endfunction

    function automatic logic checker_spin(input logic [SITE_W-1:0] s);
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        row = ROW_W'(s / SIDE);
        col = ROW_W'(s % SIDE);
        return ~(row[0] ^ col[0]);
    endfunction

endpackage

>>> rtl/core/iwce_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module iwce_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/ising_wolff_cluster_engine.sv
// Top level of the Wolff cluster engine: control sequencer, spin and pending-site RAMs.
// Depends on iwce_pkg and iwce_ram.
//
// Keeps a 64 by 64 periodic lattice of one-bit spins in a 4096 x 1 RAM and grows Wolff
// clusters with the site list in a second 4096 x 12 RAM. After reset, and after every
// load accepted outside a cluster, a sweep writes the checkerboard; no item is accepted
// during it (configuration writes still land). Read-status and rejected items answer
// in the cycle after acceptance. A start or draw item runs until the next aligned
// neighbor to be tested is found or the cluster ends: a draw is taken with its flip,
// if any, and its direction step landing at once, a start reads its seed and then flips
// it; then each list entry reached is checked against the list end, each pending-list
// entry is read, and each neighbor spin is read and tested on the lattice RAM port. One
// item is in flight at a time; the result register frees the input side as soon as the
// result is taken.
module ising_wolff_cluster_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [iwce_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic [iwce_pkg::SITE_W-1:0]   site,
    input  logic [iwce_pkg::WORD_W-1:0]   random_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic                          busy_res,
    output logic [iwce_pkg::COUNT_W-1:0]  cluster_count,
    output logic [iwce_pkg::COUNT_W-1:0]  abs_spin_sum
);
    import iwce_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED,
        ST_ADV,
        ST_PEND_RD,
        ST_PEND_WAIT,
        ST_TEST_RD,
        ST_TEST_CHK
    } state_t;

    state_t              state_reg;
    logic [WORD_W-1:0]   thr_reg;
    logic [SITE_W-1:0]   clr_reg;
    logic                load_resp_reg;
    logic [SITE_W-1:0]   site_reg;
    logic [SITE_W-1:0]   cur_reg;
    logic [COUNT_W-1:0]  rp_reg;
    logic [COUNT_W-1:0]  wc_reg;
    logic [1:0]          dir_reg;
    logic                old_reg;
    logic                in_cluster_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                out_valid_reg;
    logic                status_reg;
    logic                busy_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  abs_reg;

    logic                accept;
    logic                draw_flip;
    logic [SITE_W-1:0]   nb_site;
    logic [SITE_W-1:0]   spin_addr;
    logic                spin_we;
    logic                spin_wdata;
    logic                spin_rdata;
    logic [SITE_W-1:0]   pend_addr;
    logic                pend_we;
    logic [SITE_W-1:0]   pend_wdata;
    logic [SITE_W-1:0]   pend_rdata;
    logic signed [SUM_W-1:0] sum_abs;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign nb_site   = neighbor_of(cur_reg, dir_reg);
    assign draw_flip = accept && (operation == OP_DRAW) && in_cluster_reg
                       && (random_word < thr_reg);
    assign sum_abs   = (sum_reg < 0) ? -sum_reg : sum_reg;

    always_comb
    begin
        spin_addr  = nb_site;
        spin_we    = 1'b0;
        spin_wdata = ~old_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                spin_addr  = clr_reg;
                spin_we    = 1'b1;
                spin_wdata = checker_spin(clr_reg);
            end
            ST_IDLE:
            begin
                spin_addr = (operation == OP_START) ? site : nb_site;
                spin_we   = draw_flip;
            end
            ST_SEED:
            begin
                spin_addr  = site_reg;
                spin_we    = 1'b1;
                spin_wdata = ~spin_rdata;
            end
            default:
            begin
                spin_addr = nb_site;
            end
        endcase
    end

    always_comb
    begin
        pend_addr  = rp_reg[SITE_W-1:0];
        pend_we    = 1'b0;
        pend_wdata = nb_site;
        if (state_reg == ST_SEED)
        begin
            pend_addr  = '0;
            pend_we    = 1'b1;
            pend_wdata = site_reg;
        end
        else if (draw_flip && (wc_reg < COUNT_W'(NSITES)))
        begin
            pend_addr = wc_reg[SITE_W-1:0];
            pend_we   = 1'b1;
        end
    end

    iwce_ram #(.WIDTH(1), .DEPTH(NSITES)) u_spin_ram (
        .clk   (clk),
        .we    (spin_we),
        .addr  (spin_addr),
        .wdata (spin_wdata),
        .rdata (spin_rdata)
    );

    iwce_ram #(.WIDTH(SITE_W), .DEPTH(NSITES)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .addr  (pend_addr),
        .wdata (pend_wdata),
        .rdata (pend_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            load_resp_reg  <= 1'b0;
            site_reg       <= '0;
            cur_reg        <= '0;
            rp_reg         <= '0;
            wc_reg         <= '0;
            dir_reg        <= '0;
            old_reg        <= 1'b0;
            in_cluster_reg <= 1'b0;
            sum_reg        <= SUM_W'(CB_SUM);
            out_valid_reg  <= 1'b0;
            status_reg     <= 1'b0;
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            abs_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SITE_W'(NSITES - 1))
                    begin
                        clr_reg       <= '0;
                        sum_reg       <= SUM_W'(CB_SUM);
                        rp_reg        <= '0;
                        wc_reg        <= '0;
                        dir_reg       <= '0;
                        state_reg     <= ST_IDLE;
                        load_resp_reg <= 1'b0;
                        if (load_resp_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            status_reg    <= 1'b0;
                            busy_reg      <= 1'b0;
                            count_reg     <= '0;
                            abs_reg       <= COUNT_W'(CB_SUM);
                        end
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        // immediate answer for read and rejected items
                        status_reg <= 1'b0;
                        busy_reg   <= in_cluster_reg;
                        count_reg  <= wc_reg;
                        abs_reg    <= sum_abs[COUNT_W-1:0];
                        case (operation)
                            OP_LOAD:
                            begin
                                if (in_cluster_reg)
                                begin
                                    status_reg    <= 1'b1;
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    load_resp_reg <= 1'b1;
                                    state_reg     <= ST_CLEAR;
                                end
                            end
                            OP_START:
                            begin
                                if (in_cluster_reg
                                    || ({1'b0, site} >= (SITE_W + 1)'(NSITES)))
                                begin
                                    status_reg    <= 1'b1;
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    site_reg  <= site;
                                    state_reg <= ST_SEED;
                                end
                            end
                            OP_DRAW:
                            begin
                                if (!in_cluster_reg)
                                begin
                                    status_reg    <= 1'b1;
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    if (draw_flip)
                                    begin
                                        sum_reg <= sum_reg + (old_reg ? -SUM_W'(2)
                                                                      : SUM_W'(2));
                                        if (wc_reg < COUNT_W'(NSITES))
                                        begin
                                            wc_reg <= wc_reg + 1'b1;
                                        end
                                    end
                                    dir_reg <= dir_reg + 1'b1;
                                    if (dir_reg == DIR_RIGHT)
                                    begin
                                        rp_reg    <= rp_reg + 1'b1;
                                        state_reg <= ST_ADV;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_TEST_RD;
                                    end
                                end
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SEED:
                begin
                    old_reg        <= spin_rdata;
                    in_cluster_reg <= 1'b1;
                    sum_reg        <= sum_reg + (spin_rdata ? -SUM_W'(2) : SUM_W'(2));
                    wc_reg         <= COUNT_W'(1);
                    rp_reg         <= '0;
                    dir_reg        <= '0;
                    state_reg      <= ST_ADV;
                end
                ST_ADV:
                begin
                    if (rp_reg < wc_reg)
                    begin
                        state_reg <= ST_PEND_RD;
                    end
                    else
                    begin
                        // list exhausted: cluster done
                        in_cluster_reg <= 1'b0;
                        out_valid_reg  <= 1'b1;
                        status_reg     <= 1'b0;
                        busy_reg       <= 1'b0;
                        count_reg      <= wc_reg;
                        abs_reg        <= sum_abs[COUNT_W-1:0];
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_PEND_RD:
                begin
                    state_reg <= ST_PEND_WAIT;
                end
                ST_PEND_WAIT:
                begin
                    cur_reg   <= pend_rdata;
                    state_reg <= ST_TEST_RD;
                end
                ST_TEST_RD:
                begin
                    state_reg <= ST_TEST_CHK;
                end
                ST_TEST_CHK:
                begin
                    if (spin_rdata == old_reg)
                    begin
                        // aligned neighbor: wait for a draw
                        out_valid_reg <= 1'b1;
                        status_reg    <= 1'b0;
                        busy_reg      <= 1'b1;
                        count_reg     <= wc_reg;
                        abs_reg       <= sum_abs[COUNT_W-1:0];
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        dir_reg <= dir_reg + 1'b1;
                        if (dir_reg == DIR_RIGHT)
                        begin
                            rp_reg    <= rp_reg + 1'b1;
                            state_reg <= ST_ADV;
                        end
                        else
                        begin
                            state_reg <= ST_TEST_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign busy_res      = busy_reg;
    assign cluster_count = count_reg;
    assign abs_spin_sum  = abs_reg;

endmodule

>>> rtl/core/iwce_checker.sv
// Port-level checks for the Wolff cluster engine, bound to its top level.
// Depends on iwce_pkg.
module iwce_port_props (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [1:0]                    operation,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          status,
    input logic                          busy_res,
    input logic [iwce_pkg::COUNT_W-1:0]  cluster_count,
    input logic [iwce_pkg::COUNT_W-1:0]  abs_spin_sum
);
    import iwce_pkg::*;

    // hold a result until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");

    // a busy cluster has at least its seed
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && busy_res |-> cluster_count != '0)
        else $error("busy with empty cluster");

    a_abs_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> abs_spin_sum <= COUNT_W'(NSITES))
        else $error("spin sum out of range");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({status, busy_res, cluster_count, abs_spin_sum}))
        else $error("unknown result fields");

    // an accepted load outside a cluster starts the lattice sweep
    a_load_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == OP_LOAD) && !busy_res
        |=> !in_ready)
        else $error("load did not stall input");

endmodule

bind ising_wolff_cluster_engine iwce_port_props u_iwce_port_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .busy_res      (busy_res),
    .cluster_count (cluster_count),
    .abs_spin_sum  (abs_spin_sum)
);
